>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge, suspended while reset is active.
`define CHK_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Checked on every rising edge, reset included.
`define CHK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CHK_CLK(lbl, clk, rst_n, prop, msg)
`define CHK_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> sv/pbd_pkg.sv
package pbd_pkg;

    localparam int WORD_BITS  = 64;
    localparam int INDEX_BITS = 12;
    localparam int CNT_W      = 4;

    // Mask is handled in byte groups.
    localparam int GROUP_BITS = 8;
    localparam int GROUPS     = (WORD_BITS + GROUP_BITS - 1) / GROUP_BITS;
    localparam int PAD_BITS   = GROUPS * GROUP_BITS;

    localparam int GCNT_W = $clog2(GROUP_BITS + 1);
    localparam int ACC_W  = $clog2(PAD_BITS + 1);
    localparam int BASE_W = $clog2(INDEX_BITS + 1);
    localparam int INNER_W = $clog2(GROUP_BITS);
    localparam int RANK_W = BASE_W + INNER_W + 1;
    localparam int SEL_W  = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;
    localparam int SRC_PAD = 1 << SEL_W;

    typedef logic [GCNT_W-1:0] t_gcnt;
    typedef logic [BASE_W-1:0] t_base;

endpackage

>>> sv/parallel_bit_deposit_unit.sv
// Parallel bit deposit unit: for each request, bit k of index_word (for k below
// bit_count, which saturates at the index width) is placed at the position of
// the k-th set bit of select_mask, counted from bit 0; all other result bits are
// zero, and index bits beyond the mask's popcount are dropped. The unit takes one
// request per clock unless output back-pressure has filled the pipeline. It is a
// three-stage pipeline: per-byte mask popcount and count limiting, then a
// byte-wise running rank, then per-bit rank and selection into the output
// register. Each stage loads whenever it is empty or its contents move on, so
// bubbles fill while a result waits at the output and back-pressure loses or
// repeats nothing.
`include "assert_macros.svh"

module parallel_bit_deposit_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [pbd_pkg::WORD_BITS-1:0]   i_select_mask,
    input  logic [pbd_pkg::INDEX_BITS-1:0]  i_index_word,
    input  logic [pbd_pkg::CNT_W-1:0]       i_bit_count,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [pbd_pkg::WORD_BITS-1:0]   o_deposited_word
);
    import pbd_pkg::*;

    // Stage load enables, chained back from the output register.
    logic ld1, ld2, ld3;

    // Stage 1: padded mask, limited source, byte popcounts.
    logic                  r_v1;
    logic [PAD_BITS-1:0]   r_mask1;
    logic [INDEX_BITS-1:0] r_src1;
    t_gcnt                 r_cnt1 [GROUPS];
    logic [PAD_BITS-1:0]   n_mask1;
    logic [INDEX_BITS-1:0] n_src1;
    t_gcnt                 n_cnt1 [GROUPS];

    // Stage 2: saturated rank of the first set bit of each byte.
    logic                  r_v2;
    logic [PAD_BITS-1:0]   r_mask2;
    logic [INDEX_BITS-1:0] r_src2;
    t_base                 r_base2 [GROUPS];
    t_base                 n_base2 [GROUPS];

    // Stage 3: result.
    logic                  r_v3;
    logic [WORD_BITS-1:0]  r_out;
    logic [PAD_BITS-1:0]   n_out;

    assign ld3 = !r_v3 || i_out_ready;
    assign ld2 = !r_v2 || ld3;
    assign ld1 = !r_v1 || ld2;

    assign o_in_ready       = ld1;
    assign o_out_valid      = r_v3;
    assign o_deposited_word = r_out;

    // Number of set bits of a byte below position j.
    function automatic logic [INNER_W-1:0] ones_below(input logic [GROUP_BITS-1:0] b,
                                                      input int j);
        logic [INNER_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < GROUP_BITS - 1; k++) begin
            if (k < j && b[k]) begin
                acc = acc + INNER_W'(1);
            end
        end
        return acc;
    endfunction

    // ---- stage 1 logic ----
    always_comb begin
        n_mask1 = '0;
        n_mask1[WORD_BITS-1:0] = i_select_mask;
        for (int i = 0; i < INDEX_BITS; i++) begin
            // a count above the index width keeps every index bit
            n_src1[i] = i_index_word[i] && (i < int'(i_bit_count));
        end
        for (int g = 0; g < GROUPS; g++) begin
            n_cnt1[g] = GCNT_W'($countones(n_mask1[g*GROUP_BITS +: GROUP_BITS]));
        end
    end

    // ---- stage 2 logic: running popcount, saturated at the index width ----
    always_comb begin
        logic [ACC_W-1:0] acc;
        acc = '0;
        for (int g = 0; g < GROUPS; g++) begin
            if (acc >= ACC_W'(INDEX_BITS)) begin
                n_base2[g] = BASE_W'(INDEX_BITS);
            end else begin
                n_base2[g] = acc[BASE_W-1:0];
            end
            acc = acc + ACC_W'(r_cnt1[g]);
        end
    end

    // ---- stage 3 logic: per-bit rank and select ----
    always_comb begin
        logic [SRC_PAD-1:0] src_pad;
        logic [RANK_W-1:0]  rank;
        src_pad = '0;
        src_pad[INDEX_BITS-1:0] = r_src2;
        for (int g = 0; g < GROUPS; g++) begin
            for (int j = 0; j < GROUP_BITS; j++) begin
                rank = RANK_W'(r_base2[g])
                     + RANK_W'(ones_below(r_mask2[g*GROUP_BITS +: GROUP_BITS], j));
                n_out[g*GROUP_BITS + j] = r_mask2[g*GROUP_BITS + j]
                                       && (rank < RANK_W'(INDEX_BITS))
                                       && src_pad[rank[SEL_W-1:0]];
            end
        end
    end

    // ---- valid bits ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld1) begin
                r_v1 <= i_in_valid;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // ---- payload ----
    always_ff @(posedge i_clk) begin
        if (ld1 && i_in_valid) begin
            r_mask1 <= n_mask1;
            r_src1  <= n_src1;
            r_cnt1  <= n_cnt1;
        end
        if (ld2 && r_v1) begin
            r_mask2 <= r_mask1;
            r_src2  <= r_src1;
            r_base2 <= n_base2;
        end
        if (ld3 && r_v2) begin
            r_out <= n_out[WORD_BITS-1:0];
        end
    end

    // ---- checks ----
    `CHK_CLK(a_s2_kept, i_clk, i_rst_n, (r_v2 && !ld3) |=> r_v2, "stage 2 request lost")
    `CHK_CLK(a_s1_taken, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> r_v1, "accepted request not in stage 1")
    `CHK_CLK(a_pop_limit, i_clk, i_rst_n, r_v3 |-> ($countones(r_out) <= INDEX_BITS), "result has too many bits")
    `CHK_CLK(a_zero_src, i_clk, i_rst_n, (r_v2 && ld3 && (r_src2 == '0)) |=> (r_out == '0), "zero source gave nonzero result")
    `CHK_ALWAYS(a_rst_empty, i_clk, !$past(i_rst_n) |-> !o_out_valid, "output valid after reset")

endmodule
